// ----- rtl/core/parl_pkg.sv -----
package parl_pkg;

    localparam int TableEntries = 64;
    localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int QueueDepth = 2;

    localparam logic [2:0] CFG_WINDOW = 3'd0;
    localparam logic [2:0] CFG_BURST = 3'd1;
    localparam logic [2:0] CFG_FAST_GAP = 3'd2;
    localparam logic [2:0] CFG_BLOCK = 3'd3;
    localparam logic [2:0] CFG_EXTEND = 3'd4;

    typedef struct packed {
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [63:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [15:0] window_ms;
        logic [3:0]  burst_limit;
        logic [15:0] fast_gap_ms;
        logic [15:0] block_ms;
        logic [15:0] extend_ms;
    } cfg_t;

    typedef struct packed {
        logic [63:0] last_time;
        logic [63:0] block_until;
        logic [3:0]  count;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_OUT
    } state_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [15:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {49'd0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

// ----- rtl/core/parl_ram.sv -----
module parl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/parl_front.sv -----
module parl_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  parl_pkg::req_t s_req,
    output logic           q_valid,
    input  logic           q_pop,
    output parl_pkg::req_t q_req
);

    parl_pkg::req_t       buf_reg [parl_pkg::QueueDepth];
    logic [0:0]           wp_reg, rp_reg;
    logic [1:0]           cnt_reg;
    logic                 push;

    assign s_tready = (cnt_reg != 2'(parl_pkg::QueueDepth));
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= s_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ----- rtl/core/parl_back.sv -----
module parl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  parl_pkg::cfg_t cfg,
    input  logic           q_valid,
    output logic           q_pop,
    input  parl_pkg::req_t q_req,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [1:0]     m_data,
    output logic           busy
);

    parl_pkg::state_t state_reg, state_next;
    logic [parl_pkg::TableEntries-1:0] valid_reg;
    logic [parl_pkg::IdxW-1:0]  scan_reg;
    logic                       scan_v_reg;
    logic                       chk_v_reg;
    logic                       hit_reg;
    logic [parl_pkg::IdxW-1:0]  hit_idx_reg;
    logic                       free_reg;
    logic [parl_pkg::IdxW-1:0]  free_idx_reg;
    logic [1:0]                 res_reg;
    logic [parl_pkg::IdxW-1:0]  rd_idx_reg;

    logic [63:0]                ahi_rd, alo_rd;
    parl_pkg::rec_t             rec_rd, rec_wr;
    logic                       rec_we, adr_we;
    logic [parl_pkg::IdxW-1:0]  wr_idx, rd_idx;
    logic                       last_scan, scan_done, match;
    logic [1:0]                 res_next;
    logic [63:0]                gap;
    logic [4:0]                 cnt_inc;

    parl_ram #(.Width(64), .Depth(parl_pkg::TableEntries)) u_ahi (
        .clk(clk), .we(adr_we), .waddr(wr_idx), .wdata(q_req.address_high),
        .raddr(rd_idx), .rdata(ahi_rd)
    );
    parl_ram #(.Width(64), .Depth(parl_pkg::TableEntries)) u_alo (
        .clk(clk), .we(adr_we), .waddr(wr_idx), .wdata(q_req.address_low),
        .raddr(rd_idx), .rdata(alo_rd)
    );
    parl_ram #(.Width($bits(parl_pkg::rec_t)), .Depth(parl_pkg::TableEntries)) u_rec (
        .clk(clk), .we(rec_we), .waddr(wr_idx), .wdata(rec_wr),
        .raddr(rd_idx), .rdata(rec_rd)
    );

    assign last_scan = (scan_reg == parl_pkg::IdxW'(parl_pkg::TableEntries - 1));
    assign scan_done = !scan_v_reg && !chk_v_reg && last_scan;
    assign rd_idx = (state_reg == parl_pkg::ST_WAIT) ? hit_idx_reg : scan_reg;
    assign match = chk_v_reg && valid_reg[rd_idx_reg]
        && (ahi_rd == q_req.address_high) && (alo_rd == q_req.address_low);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            parl_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = parl_pkg::ST_SCAN;
                end
            end
            parl_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = hit_reg ? parl_pkg::ST_WAIT : parl_pkg::ST_OUT;
                end
            end
            parl_pkg::ST_WAIT:   state_next = parl_pkg::ST_DECIDE;
            parl_pkg::ST_DECIDE: state_next = parl_pkg::ST_OUT;
            parl_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = parl_pkg::ST_IDLE;
                end
            end
            default: state_next = parl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        gap = (q_req.now_ms >= rec_rd.last_time) ? q_req.now_ms - rec_rd.last_time : 64'd0;
        cnt_inc = {1'b0, rec_rd.count} + 5'd1;
        rec_wr = rec_rd;
        res_next = 2'b01;
        rec_we = 1'b0;
        adr_we = 1'b0;
        wr_idx = hit_idx_reg;
        case (state_reg)
            parl_pkg::ST_SCAN:
            begin
                if (scan_done && !hit_reg)
                begin
                    wr_idx = free_idx_reg;
                    if (free_reg)
                    begin
                        adr_we = 1'b1;
                        rec_we = 1'b1;
                        rec_wr.last_time = q_req.now_ms;
                        rec_wr.block_until = 64'd0;
                        rec_wr.count = 4'd1;
                    end
                    else
                    begin
                        res_next = 2'b11;
                    end
                end
            end
            parl_pkg::ST_DECIDE:
            begin
                rec_we = 1'b1;
                if (rec_rd.block_until > q_req.now_ms)
                begin
                    rec_wr.block_until = parl_pkg::sat_add(rec_rd.block_until, cfg.extend_ms);
                    res_next = 2'b00;
                end
                else
                begin
                    rec_wr.last_time = q_req.now_ms;
                    if (gap <= {48'd0, cfg.window_ms})
                    begin
                        if (cnt_inc > {1'b0, cfg.burst_limit})
                        begin
                            rec_wr.count = 4'd0;
                            if (gap <= {48'd0, cfg.fast_gap_ms})
                            begin
                                rec_wr.block_until =
                                    parl_pkg::sat_add(q_req.now_ms, cfg.block_ms);
                                res_next = 2'b00;
                            end
                        end
                        else
                        begin
                            rec_wr.count = cnt_inc[3:0];
                        end
                    end
                    else
                    begin
                        rec_wr.count = 4'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = (state_reg == parl_pkg::ST_OUT);
    assign m_data = res_reg;
    assign q_pop = m_tvalid && m_tready;
    assign busy = (state_reg != parl_pkg::ST_IDLE) || q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= parl_pkg::ST_IDLE;
            valid_reg <= '0;
            scan_reg <= '0;
            scan_v_reg <= 1'b0;
            chk_v_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
            rd_idx_reg <= '0;
            res_reg <= 2'b01;
        end
        else
        begin
            state_reg <= state_next;
            rd_idx_reg <= rd_idx;
            if (state_reg == parl_pkg::ST_IDLE)
            begin
                scan_reg <= '0;
                scan_v_reg <= q_valid;
                chk_v_reg <= 1'b0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (state_reg == parl_pkg::ST_SCAN)
            begin
                chk_v_reg <= scan_v_reg;
                if (chk_v_reg)
                begin
                    if (!hit_reg && match)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                    if (!free_reg && !valid_reg[rd_idx_reg])
                    begin
                        free_reg <= 1'b1;
                        free_idx_reg <= rd_idx_reg;
                    end
                end
                if (last_scan)
                begin
                    scan_v_reg <= 1'b0;
                end
                else
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            if (adr_we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if ((state_reg == parl_pkg::ST_SCAN && state_next != parl_pkg::ST_SCAN)
                || state_reg == parl_pkg::ST_DECIDE)
            begin
                res_reg <= res_next;
            end
        end
    end

endmodule

// ----- rtl/core/per_address_connection_rate_limiter_core.sv -----
// Channel  | Direction | Handshake              | Payload
// s_axis   | in        | s_tvalid / s_tready    | address_high, address_low, now_ms
// m_axis   | out       | m_tvalid / m_tready    | accepted, table_full
// cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A word passes the idle state, then a scan of all 64 table entries through the
// registered RAM read port; a known address then gets a read-modify-write of
// the matching entry, and a new one is written to a free entry if there is one.
// A two-word queue in front holds the word being worked on and takes one more.
// Reset clears the valid bits and the registers; the table needs no sweep.
// A stalled result holds the back end until m_tready.
module per_address_connection_rate_limiter_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // address_high, address_low, now_ms
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // accepted, table_full, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    parl_pkg::cfg_t cfg_reg;
    parl_pkg::req_t s_req, q_req;
    logic           q_valid, q_pop, busy;
    logic [1:0]     res;

    assign s_req.address_high = s_tdata[63:0];
    assign s_req.address_low = s_tdata[127:64];
    assign s_req.now_ms = s_tdata[191:128];
    assign cfg_ready = 1'b1;
    assign m_tdata = {6'd0, res[1], res[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms <= 16'd5000;
            cfg_reg.burst_limit <= 4'd5;
            cfg_reg.fast_gap_ms <= 16'd500;
            cfg_reg.block_ms <= 16'd3000;
            cfg_reg.extend_ms <= 16'd250;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                parl_pkg::CFG_WINDOW:   cfg_reg.window_ms <= cfg_data;
                parl_pkg::CFG_BURST:    cfg_reg.burst_limit <= cfg_data[3:0];
                parl_pkg::CFG_FAST_GAP: cfg_reg.fast_gap_ms <= cfg_data;
                parl_pkg::CFG_BLOCK:    cfg_reg.block_ms <= cfg_data;
                parl_pkg::CFG_EXTEND:   cfg_reg.extend_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    parl_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_req(s_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    parl_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_valid(q_valid), .q_pop(q_pop),
        .q_req(q_req), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_data(res),
        .busy(busy)
    );

`ifndef SYNTHESIS
    a_full_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("table_full result without accept");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_out_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> busy)
        else $error("result without queued word");
`endif

endmodule
